// ===== sv/wsfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed frame parser package
// Frame marker bytes, result status codes, the CRC-8 byte update and the
// result bundle passed from the frame core to the top level.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] CMD_FIRST   = 8'hA5;
  localparam logic [7:0] CMD_SECOND  = 8'h5A;
  localparam logic [7:0] TAIL_FIRST  = 8'h0D;
  localparam logic [7:0] TAIL_SECOND = 8'h0A;
  localparam logic [7:0] CRC_POLY    = 8'h8C;

  localparam int unsigned NUM_WHEELS = 4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HEADER   = 3'd1,
    ST_COMMAND  = 3'd2,
    ST_TRAILER  = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_t;

  typedef logic [15:0] word_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_length;
    word_t [NUM_WHEELS-1:0] words;
  } result_t;

  // Reflected CRC-8 update for one byte, least significant bit first.
  function automatic logic [7:0] crc8_feed(logic [7:0] crc_in, logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/wsfp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed frame core
// Holds the frame tracking state and works out, for one byte, the next state
// and whether that byte ends a frame or a failed header with a result.
// ----------------------------------------------------------------------------
module wsfp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data,
  output logic                has_result,
  output wsfp_pkg::result_t   result
);

  logic [8:0] pos, pos_next;
  logic [7:0] frame_len, frame_len_next;
  logic [7:0] crc, crc_next;
  logic [7:0] rx_crc, rx_crc_next;
  logic       cmd_bad, cmd_bad_next;
  logic       tail_bad, tail_bad_next;
  wsfp_pkg::word_t [wsfp_pkg::NUM_WHEELS-1:0] words, words_next;

  logic [8:0] len9;
  logic [8:0] crc_pos;
  logic [8:0] tail_pos;
  logic [8:0] last_pos;
  logic [2:0] word_off;
  logic [7:0] crc_feed_val;

  assign len9         = {1'b0, frame_len};
  assign crc_pos      = len9 + 9'd5;
  assign tail_pos     = len9 + 9'd6;
  assign last_pos     = len9 + 9'd7;
  assign word_off     = 3'(pos - 9'd5);
  assign crc_feed_val = wsfp_pkg::crc8_feed(crc, data);

  always_comb begin
    pos_next       = pos;
    frame_len_next = frame_len;
    crc_next       = crc;
    rx_crc_next    = rx_crc;
    cmd_bad_next   = cmd_bad;
    tail_bad_next  = tail_bad;
    words_next     = words;
    has_result     = 1'b0;
    result.status  = wsfp_pkg::ST_OK;
    result.payload_length = 8'd0;

    if (pos == 9'd0) begin
      if (data == wsfp_pkg::SYNC_FIRST) begin
        words_next     = '0;
        cmd_bad_next   = 1'b0;
        tail_bad_next  = 1'b0;
        frame_len_next = 8'd0;
        rx_crc_next    = 8'd0;
        crc_next       = wsfp_pkg::crc8_feed(8'd0, data);
        pos_next       = 9'd1;
      end
    end else if (pos == 9'd1) begin
      if (data != wsfp_pkg::SYNC_SECOND) begin
        pos_next      = 9'd0;
        has_result    = 1'b1;
        result.status = wsfp_pkg::ST_HEADER;
      end else begin
        crc_next = crc_feed_val;
        pos_next = 9'd2;
      end
    end else if (pos <= 9'd4) begin
      if (pos == 9'd2 && data != wsfp_pkg::CMD_FIRST) cmd_bad_next = 1'b1;
      if (pos == 9'd3 && data != wsfp_pkg::CMD_SECOND) cmd_bad_next = 1'b1;
      if (pos == 9'd4) frame_len_next = data;
      crc_next = crc_feed_val;
      pos_next = pos + 9'd1;
    end else if (pos > last_pos) begin
      pos_next = 9'd0;
    end else begin
      // Offsets 5 to 12 fill the speed words, high byte on odd offsets.
      if (pos <= 9'd12) begin
        if (!word_off[0]) begin
          words_next[word_off[2:1]][15:8] = data;
        end else begin
          words_next[word_off[2:1]][7:0] = data;
        end
      end
      pos_next = pos + 9'd1;
      if (pos < crc_pos) begin
        crc_next = crc_feed_val;
      end else if (pos == crc_pos) begin
        rx_crc_next = data;
      end else if (pos == tail_pos) begin
        if (data != wsfp_pkg::TAIL_FIRST) tail_bad_next = 1'b1;
      end else begin
        if (data != wsfp_pkg::TAIL_SECOND) tail_bad_next = 1'b1;
        pos_next              = 9'd0;
        has_result            = 1'b1;
        result.payload_length = frame_len;
        if (cmd_bad) begin
          result.status = wsfp_pkg::ST_COMMAND;
        end else if (tail_bad_next) begin
          result.status = wsfp_pkg::ST_TRAILER;
        end else if (crc != rx_crc) begin
          result.status = wsfp_pkg::ST_CHECKSUM;
        end else begin
          result.status = wsfp_pkg::ST_OK;
        end
      end
    end
    result.words = words_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 9'd0;
      frame_len <= 8'd0;
      crc       <= 8'd0;
      rx_crc    <= 8'd0;
      cmd_bad   <= 1'b0;
      tail_bad  <= 1'b0;
      words     <= '0;
    end else if (step) begin
      pos       <= pos_next;
      frame_len <= frame_len_next;
      crc       <= crc_next;
      rx_crc    <= rx_crc_next;
      cmd_bad   <= cmd_bad_next;
      tail_bad  <= tail_bad_next;
      words     <= words_next;
    end
  end

  // Inside the payload region the position never runs past the trailer.
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (pos > 9'd4) |-> (pos <= last_pos))
    else $error("frame position beyond end of frame");

  // A result is only produced on a failed second sync byte or a frame end.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    has_result |-> (pos == 9'd1 || pos == last_pos))
    else $error("result from an unexpected frame position");

endmodule

// ===== sv/wheel_speed_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed frame parser
// Hunts received serial bytes for sync 55 AA, command A5 5A, a length byte,
// the payload, a reflected CRC-8 and the trailer 0D 0A, and reports a status
// with four big-endian wheel speed words per frame or failed header.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | rx_byte
//  output  | out_valid / out_ready| status, payload_length, speed_left_front,
//          |                      | speed_right_front, speed_right_back,
//          |                      | speed_left_back
//
// One byte beat is accepted per cycle unless a result is blocked at a stalled
// output. A byte waits in the input register, where the frame core updates
// the parse state and decides on a result; the output register loads that
// result when the byte moves on. Reset clears the parse state and both
// valid flags.
// A stalled output holds the waiting result; bytes that cause no result keep
// flowing, and in_ready drops while a byte with a blocked result waits.
// ----------------------------------------------------------------------------
module wheel_speed_frame_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  payload_length,
  output logic [15:0] speed_left_front,
  output logic [15:0] speed_right_front,
  output logic [15:0] speed_right_back,
  output logic [15:0] speed_left_back
);

  // Input register stage.
  logic       byte_valid;
  logic [7:0] byte_q;

  // Frame core interface.
  logic              advance;
  logic              has_result;
  wsfp_pkg::result_t result;

  // Output register.
  wsfp_pkg::result_t out_q;

  // The buffered byte moves on unless it makes a result that would overwrite
  // a result still waiting at the output.
  assign advance  = byte_valid && (!has_result || !out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  wsfp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data       (byte_q),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        byte_valid <= in_valid;
      end
      if (advance && has_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  assign status            = out_q.status;
  assign payload_length    = out_q.payload_length;
  assign speed_left_front  = out_q.words[0];
  assign speed_right_front = out_q.words[1];
  assign speed_right_back  = out_q.words[2];
  assign speed_left_back   = out_q.words[3];

  // Status codes above the checksum error never reach the output.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= wsfp_pkg::ST_CHECKSUM))
    else $error("status code out of range");

  // A header error carries no length and cleared speed words.
  a_header_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == wsfp_pkg::ST_HEADER) |->
      (payload_length == 8'd0 && speed_left_front == 16'd0 &&
       speed_right_front == 16'd0 && speed_right_back == 16'd0 &&
       speed_left_back == 16'd0))
    else $error("header error with nonzero fields");

  // The buffered byte only waits when its result is blocked by a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !advance) |-> (out_valid && !out_ready && has_result))
    else $error("input stage stalled without a blocked result");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed frame parser testbench
// Streams serial bytes into the parser: a handful of hand-picked bytes and
// frames, then about two thousand random bytes. Most of these are
// well-formed frames with random payloads. The rest are frames with faults
// in the sync, command, checksum or trailer bytes, cut-off frames and line
// noise. A byte-level model of the parser predicts every status report.
// Each report taken from the output is compared with the oldest prediction,
// field by field. Both handshake sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ITEM_TARGET  = 1950;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PRINT_LIMIT  = 30;

  // Kinds of frame the random stimulus can build.
  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_SYNC,
    FRAME_BAD_COMMAND,
    FRAME_BAD_TRAILER,
    FRAME_BAD_CHECKSUM,
    FRAME_MIXED,
    FRAME_CUT
  } frame_fault_t;

  // One status report as the parser should give it. Index 0 of speed is
  // the left front wheel, then right front, right back and left back.
  typedef struct packed {
    wsfp_pkg::status_t status;
    logic [7:0]        plen;
    logic [3:0][15:0]  speed;
  } frame_report_t;

  // --------------------------------------------------------------------------
  // Parser model. It follows the frame byte by byte, keeps its own copy of
  // the parse state and queues the report that each byte causes, if any.
  // --------------------------------------------------------------------------
  class frame_result_tracker;
    int unsigned   frame_pos;
    logic [7:0]    frame_len;
    logic [7:0]    crc_run;
    logic [7:0]    crc_seen;
    bit            command_bad;
    bit            trailer_bad;
    logic [15:0]   speed_word [4];
    frame_report_t pending_reports [$];
    int unsigned   mismatches;

    function new();
      frame_pos   = 0;
      frame_len   = '0;
      crc_run     = '0;
      crc_seen    = '0;
      command_bad = 1'b0;
      trailer_bad = 1'b0;
      foreach (speed_word[i]) speed_word[i] = '0;
      mismatches  = 0;
    endfunction

    // Reflected CRC-8 over one byte, shifting out the low bit each step.
    static function logic [7:0] crc8_byte(logic [7:0] acc, logic [7:0] data);
      logic [7:0] c;
      c = acc ^ data;
      repeat (8) begin
        if (c[0]) begin
          c = {1'b0, c[7:1]} ^ wsfp_pkg::CRC_POLY;
        end else begin
          c = {1'b0, c[7:1]};
        end
      end
      return c;
    endfunction

    function void queue_report(wsfp_pkg::status_t st, logic [7:0] len);
      frame_report_t r;
      r.status = st;
      r.plen   = len;
      for (int i = 0; i < 4; i++) r.speed[i] = speed_word[i];
      pending_reports.push_back(r);
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction

    // Advances the model by one accepted byte beat.
    function void take_byte(logic [7:0] b);
      int unsigned       len;
      int unsigned       idx;
      wsfp_pkg::status_t st;
      len = frame_len;
      if (frame_pos == 0) begin
        // Hunting: only the first sync byte starts a frame.
        if (b == wsfp_pkg::SYNC_FIRST) begin
          foreach (speed_word[i]) speed_word[i] = '0;
          command_bad = 1'b0;
          trailer_bad = 1'b0;
          frame_len   = '0;
          crc_seen    = '0;
          crc_run     = crc8_byte(8'h00, b);
          frame_pos   = 1;
        end
        return;
      end
      if (frame_pos == 1) begin
        // A wrong second sync byte is reported at once and consumed.
        if (b != wsfp_pkg::SYNC_SECOND) begin
          frame_pos = 0;
          queue_report(wsfp_pkg::ST_HEADER, 8'h00);
          return;
        end
        crc_run   = crc8_byte(crc_run, b);
        frame_pos = 2;
        return;
      end
      if (frame_pos <= 4) begin
        if (frame_pos == 2 && b != wsfp_pkg::CMD_FIRST) command_bad = 1'b1;
        if (frame_pos == 3 && b != wsfp_pkg::CMD_SECOND) command_bad = 1'b1;
        if (frame_pos == 4) frame_len = b;
        crc_run   = crc8_byte(crc_run, b);
        frame_pos = frame_pos + 1;
        return;
      end
      if (frame_pos > 7 + len) begin
        frame_pos = 0;
        return;
      end
      // Offsets 5 to 12 fill the speed words, high byte first.
      if (frame_pos <= 12) begin
        idx = (frame_pos - 5) >> 1;
        if (frame_pos[0]) begin
          speed_word[idx][15:8] = b;
        end else begin
          speed_word[idx][7:0] = b;
        end
      end
      if (frame_pos < 5 + len) begin
        crc_run = crc8_byte(crc_run, b);
      end else if (frame_pos == 5 + len) begin
        crc_seen = b;
      end else if (frame_pos == 6 + len) begin
        if (b != wsfp_pkg::TAIL_FIRST) trailer_bad = 1'b1;
      end else begin
        if (b != wsfp_pkg::TAIL_SECOND) trailer_bad = 1'b1;
        if (command_bad) begin
          st = wsfp_pkg::ST_COMMAND;
        end else if (trailer_bad) begin
          st = wsfp_pkg::ST_TRAILER;
        end else if (crc_run != crc_seen) begin
          st = wsfp_pkg::ST_CHECKSUM;
        end else begin
          st = wsfp_pkg::ST_OK;
        end
        frame_pos = 0;
        queue_report(st, frame_len);
        return;
      end
      frame_pos = (frame_pos + 1) & 9'h1FF;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want) begin
        report_mismatch($sformatf("%s got %0h, predicted %0h", name, got, want));
      end
    endtask

    // Compares one report beat from the output with the oldest prediction.
    task match_report(logic [2:0] got_status, logic [7:0] got_len,
                      logic [15:0] lf, logic [15:0] rf,
                      logic [15:0] rb, logic [15:0] lb);
      frame_report_t want;
      if (pending_reports.size() == 0) begin
        report_mismatch("report beat with no report predicted");
        return;
      end
      want = pending_reports.pop_front();
      check_field("status", got_status, want.status);
      check_field("payload_length", got_len, want.plen);
      check_field("speed_left_front", lf, want.speed[0]);
      check_field("speed_right_front", rf, want.speed[1]);
      check_field("speed_right_back", rb, want.speed[2]);
      check_field("speed_left_back", lb, want.speed[3]);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself. Every input has a known value from
  // time zero on.
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  payload_length;
  logic [15:0] speed_left_front;
  logic [15:0] speed_right_front;
  logic [15:0] speed_right_back;
  logic [15:0] speed_left_back;

  frame_result_tracker tracker = new();

  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  bit          in_steady   = 1'b0;
  bit          out_steady  = 1'b0;

  always #10 clk = ~clk;

  wheel_speed_frame_parser_top dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .payload_length    (payload_length),
    .speed_left_front  (speed_left_front),
    .speed_right_front (speed_right_front),
    .speed_right_back  (speed_right_back),
    .speed_left_back   (speed_left_back)
  );

  // A hung handshake or a lost report ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Byte driver. It is entered and left at a falling edge. The gap before
  // the beat lowers in_valid only when the gap is nonzero, so back-to-back
  // beats keep in_valid high without a glitch. The model sees the byte at
  // the rising edge where the beat is taken.
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  // Builds one frame with a random payload of plen bytes and a correct CRC,
  // then breaks it as the fault kind says and sends it.
  task automatic send_frame(frame_fault_t fault, int unsigned plen);
    logic [7:0]  frame_bytes [$];
    logic [7:0]  crc;
    int unsigned stop;
    frame_bytes = {wsfp_pkg::SYNC_FIRST, wsfp_pkg::SYNC_SECOND, wsfp_pkg::CMD_FIRST,
                   wsfp_pkg::CMD_SECOND, 8'(plen)};
    for (int unsigned k = 0; k < plen; k++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    crc = 8'h00;
    foreach (frame_bytes[k]) crc = frame_result_tracker::crc8_byte(crc, frame_bytes[k]);
    frame_bytes.push_back(crc);
    frame_bytes.push_back(wsfp_pkg::TAIL_FIRST);
    frame_bytes.push_back(wsfp_pkg::TAIL_SECOND);
    stop = frame_bytes.size();

    // A flip with a nonzero mask is sure to change the byte.
    case (fault)
      FRAME_BAD_SYNC: begin
        // A repeated first sync byte is still an error and does not restart.
        if ($urandom_range(0, 3) == 0) begin
          frame_bytes[1] = wsfp_pkg::SYNC_FIRST;
        end else begin
          frame_bytes[1] ^= 8'($urandom_range(1, 255));
        end
        // The rest of the frame then reaches the parser as noise, or not.
        if ($urandom_range(0, 1) == 0) stop = 2;
      end
      FRAME_BAD_COMMAND: begin
        frame_bytes[2 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      end
      FRAME_BAD_TRAILER: begin
        frame_bytes[6 + plen + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      end
      FRAME_BAD_CHECKSUM: begin
        frame_bytes[5 + plen] ^= 8'($urandom_range(1, 255));
      end
      FRAME_MIXED: begin
        // Several faults at once exercise the priority of the status codes.
        if ($urandom_range(0, 1) == 1) frame_bytes[2 + $urandom_range(0, 1)] ^= 8'h5A;
        if ($urandom_range(0, 1) == 1) frame_bytes[6 + plen + $urandom_range(0, 1)] ^= 8'h81;
        if ($urandom_range(0, 1) == 1) frame_bytes[5 + plen] ^= 8'($urandom_range(1, 255));
      end
      FRAME_CUT: begin
        // The bytes of the next frame then complete this one.
        stop = $urandom_range(2, frame_bytes.size() - 2);
      end
      default: begin
      end
    endcase

    for (int unsigned k = 0; k < stop; k++) send_byte(frame_bytes[k]);
  endtask

  // --------------------------------------------------------------------------
  // Report receiver. Before each report it may hold out_ready low for a
  // random stall; now and then it switches to a stretch with no stalls.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.match_report(status, payload_length, speed_left_front,
                           speed_right_front, speed_right_back, speed_left_back);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned plen;
    int unsigned burst;
    int unsigned lsel;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: noise at both ends of the byte range, a second sync
    // byte that is the first sync byte again, an ordinary bad second sync
    // byte, then the shortest frame both clean and with a command fault.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(wsfp_pkg::SYNC_FIRST);
    send_byte(wsfp_pkg::SYNC_FIRST);
    send_byte(wsfp_pkg::SYNC_FIRST);
    send_byte(8'h00);
    send_frame(FRAME_GOOD, 0);
    send_frame(FRAME_BAD_COMMAND, 0);

    // Random part. Mostly well-formed frames with random payloads; lengths
    // are mostly short so that the speed words often overlap the checksum
    // and trailer, with a few long frames up to the largest length.
    while (items_sent < ITEM_TARGET) begin
      in_steady = ($urandom_range(0, 5) == 0);
      lsel = $urandom_range(0, 99);
      if (lsel < 85) begin
        plen = $urandom_range(0, 12);
      end else if (lsel < 97) begin
        plen = $urandom_range(13, 40);
      end else if (lsel == 99) begin
        plen = 255;
      end else begin
        plen = $urandom_range(200, 255);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(FRAME_GOOD, plen);
      end else if (pick < 63) begin
        send_frame(FRAME_BAD_COMMAND, plen);
      end else if (pick < 71) begin
        send_frame(FRAME_BAD_TRAILER, plen);
      end else if (pick < 79) begin
        send_frame(FRAME_BAD_CHECKSUM, plen);
      end else if (pick < 85) begin
        send_frame(FRAME_BAD_SYNC, plen);
      end else if (pick < 89) begin
        send_frame(FRAME_MIXED, plen);
      end else if (pick < 93) begin
        send_frame(FRAME_CUT, plen);
      end else begin
        // Line noise between frames; a stray sync byte here opens a frame
        // that the following bytes then fill.
        burst = $urandom_range(1, 6);
        repeat (burst) send_byte(8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    // Wait for every predicted report, then go on through a drain period so
    // that a spurious late report would still be caught.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
